// File: sv/aes_ctr_pkg.sv
// ----------------------------------------------------------------------------
// AES counter package
// Shared constants, S-box and round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_ctr_pkg;

  localparam int MaxRunDefault = 64;
  localparam int KeyWidth = 64;
  localparam int CfgIndexWidth = 1;
  localparam logic [CfgIndexWidth-1:0] RegKeyLow = 1'b0;
  localparam logic [CfgIndexWidth-1:0] RegKeyHigh = 1'b1;
  localparam logic OpEcb = 1'b0;
  localparam logic OpCtr = 1'b1;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tab [0:255];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round constant: doubling in GF(2^8).
  function automatic logic [7:0] rcon_next(input logic [7:0] r);
    return xtime(r);
  endfunction

endpackage
`default_nettype wire

// File: sv/aes_ctr_round.sv
// ----------------------------------------------------------------------------
// AES counter round unit
// One cipher round and one key schedule step, reused for every round.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ctr_round (
  input  wire logic [127:0] state,
  input  wire logic [127:0] round_key,
  input  wire logic [7:0]   rcon,
  input  wire logic         final_round,
  output logic      [127:0] state_next,
  output logic      [127:0] round_key_next
);

  logic [7:0] s [0:15];
  logic [7:0] t [0:15];
  logic [7:0] m [0:15];
  logic [31:0] w [0:3];
  logic [31:0] rot;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state[8*i +: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = aes_ctr_pkg::sbox(s[4*((c+r)%4)+r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = t[4*c] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3])
                 ^ aes_ctr_pkg::xtime(t[4*c]^t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3])
                 ^ aes_ctr_pkg::xtime(t[4*c+1]^t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3])
                 ^ aes_ctr_pkg::xtime(t[4*c+2]^t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3])
                 ^ aes_ctr_pkg::xtime(t[4*c+3]^t[4*c]);
    end
    // Key schedule: words stored byte 0 in low bits.
    for (int k = 0; k < 4; k++) begin
      w[k] = round_key[32*k +: 32];
    end
    rot = {aes_ctr_pkg::sbox(w[3][7:0]), aes_ctr_pkg::sbox(w[3][31:24]),
           aes_ctr_pkg::sbox(w[3][23:16]), aes_ctr_pkg::sbox(w[3][15:8]) ^ rcon};
    round_key_next[31:0]   = w[0] ^ rot;
    round_key_next[63:32]  = w[1] ^ w[0] ^ rot;
    round_key_next[95:64]  = w[2] ^ w[1] ^ w[0] ^ rot;
    round_key_next[127:96] = w[3] ^ w[2] ^ w[1] ^ w[0] ^ rot;
    for (int i = 0; i < 16; i++) begin
      state_next[8*i +: 8] = (final_round ? t[i] : m[i]) ^ round_key_next[8*i +: 8];
    end
  end

endmodule
`default_nettype wire

// File: sv/aes128_encrypt_ecb_counter_top.sv
// ----------------------------------------------------------------------------
// AES-128 encryptor, ECB and counter modes
// Iterative core: one shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
// Start loads the whitened block; the shared round unit then runs one round
// per cycle, and the output word is registered from the pass of round ten.
// A new start is taken only once busy is low. In a counter run the next index
// is whitened on the edge that issues a word, so the round unit does not idle
// between the words of a run.
// busy stays high until the last word; the receiver cannot stall.
// Synchronous active-high reset clears the key registers and the sequencer.
`default_nettype none
module aes128_encrypt_ecb_counter_top #(
  parameter int MAX_RUN = aes_ctr_pkg::MaxRunDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [aes_ctr_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [aes_ctr_pkg::KeyWidth-1:0]      cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [63:0] data_low,
  input  wire logic [63:0] data_high,
  input  wire logic [63:0] counter_start,
  input  wire logic [6:0]  block_count,
  output logic             out_valid,
  output logic      [63:0] out_low,
  output logic      [63:0] out_high,
  output logic             last
);

  localparam logic [6:0] MaxRunCount = 7'(MAX_RUN);

  logic [63:0]  key_low;
  logic [63:0]  key_high;
  logic [127:0] state;
  logic [127:0] round_key;
  logic [7:0]   rcon;
  logic [3:0]   round;      // round being computed, 1..10
  logic [63:0]  index;      // counter index of the current block
  logic [6:0]   remaining;  // blocks still to produce, including this one
  logic [127:0] state_next;
  logic [127:0] round_key_next;
  logic [127:0] key_full;
  logic         final_round;

  assign key_full = {key_high, key_low};
  assign final_round = (round == 4'd10);

  aes_ctr_round u_round (
    .state          (state),
    .round_key      (round_key),
    .rcon           (rcon),
    .final_round    (final_round),
    .state_next     (state_next),
    .round_key_next (round_key_next)
  );

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes_ctr_pkg::RegKeyLow:  key_low  <= cfg_data;
        aes_ctr_pkg::RegKeyHigh: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer. On start the whitened block is loaded; each following cycle
  // runs one round. After round ten a word goes out and the next index is
  // whitened in the same edge, for a counter run with blocks left.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      round     <= 4'd0;
      remaining <= '0;
    end else begin
      out_valid <= 1'b0;
      if (!busy) begin
        if (start) begin
          if (operation == aes_ctr_pkg::OpEcb) begin
            state     <= {data_high, data_low} ^ key_full;
            remaining <= 7'd1;
            busy      <= 1'b1;
          end else begin
            state     <= {64'd0, counter_start} ^ key_full;
            remaining <= (block_count > MaxRunCount) ? MaxRunCount : block_count;
            busy      <= (block_count != 7'd0);
          end
          index     <= counter_start;
          round_key <= key_full;
          rcon      <= 8'h01;
          round     <= 4'd1;
        end
      end else if (final_round) begin
        out_valid <= 1'b1;
        out_low   <= state_next[63:0];
        out_high  <= state_next[127:64];
        last      <= (remaining == 7'd1);
        remaining <= remaining - 7'd1;
        if (remaining == 7'd1) begin
          busy <= 1'b0;
        end
        state     <= {64'd0, index + 64'd1} ^ key_full;
        index     <= index + 64'd1;
        round_key <= key_full;
        rcon      <= 8'h01;
        round     <= 4'd1;
      end else begin
        state     <= state_next;
        round_key <= round_key_next;
        rcon      <= aes_ctr_pkg::rcon_next(rcon);
        round     <= round + 4'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/aes_ctr_checker.sv
// ----------------------------------------------------------------------------
// AES counter port checker
// Watches the top level's ports for sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ctr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic operation,
  input wire logic out_valid,
  input wire logic last
);

  // A word only appears while a run is in progress.
  a_word_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(busy)) else $error("word outside a run");

  // An ECB start yields its only word, marked last.
  a_ecb_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == aes_ctr_pkg::OpEcb) |-> ##11 (out_valid && last)
    ) else $error("ECB word missing eleven cycles after start");

  // The last word ends the run.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> !busy) else $error("busy after last word");

  // Words never come out back to back.
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    out_valid |=> !out_valid) else $error("back-to-back words");

endmodule

bind aes128_encrypt_ecb_counter_top aes_ctr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .out_valid (out_valid),
  .last      (last)
);
`default_nettype wire
